FILE: hw/rtl/vt_pkg.sv
// vt_pkg: shared types and constants for the vertex transform engine
// holds the queued item type, the queue head type and the field widths
// no dependencies
package vt_pkg;

	// component and word widths
	localparam int COMP_W      = 32;
	localparam int NUM_COMP    = 4;
	localparam int NUM_COEF    = NUM_COMP * NUM_COMP;
	localparam int IDX_W       = $clog2(NUM_COEF);
	localparam int PROD_W      = 2 * COMP_W;
	localparam int SUM_W       = PROD_W + 2;

	// default fraction bits of the fixed point format
	localparam int FRAC_BITS_DEF = 16;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// stream widths, tdata rounded up to whole bytes
	localparam int IN_FIELDS_W  = IDX_W + COMP_W + NUM_COMP * COMP_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = NUM_COMP * COMP_W;

	// item kinds carried in tuser
	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_XFORM = 1'b1
	} kind_t;

	typedef logic signed [COMP_W-1:0] comp_t;

	// classified item; for a load, data[0] holds the coefficient value
	typedef struct packed {
		kind_t                   kind;
		logic [IDX_W-1:0]        coef_index;
		comp_t [NUM_COMP-1:0]    data;
	} item_t;

	// queue head seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

FILE: hw/rtl/vt_front.sv
// vt_front: input side of the vertex transform engine
// accepts beats, classifies them into items and holds them in a short queue
// depends on vt_pkg
module vt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// coef_index, coef_value, in_x, in_y, in_z, in_w, zero pad (lowest bit first)
	input  logic [vt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// kind
	input  logic                          s_axis_tuser,
	output vt_pkg::head_t                 head,
	input  logic                          pop
);

	localparam int DEPTH = vt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = vt_pkg::COMP_W;
	localparam int IW    = vt_pkg::IDX_W;

	vt_pkg::item_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	vt_pkg::item_t      item_in;
	logic               push;
	logic               do_pop;

	// classify the incoming beat
	always_comb begin
		item_in.kind       = vt_pkg::kind_t'(s_axis_tuser);
		item_in.coef_index = s_axis_tdata[IW-1:0];
		if (item_in.kind == vt_pkg::KIND_LOAD) begin
			item_in.data    = '0;
			item_in.data[0] = s_axis_tdata[IW +: CW];
		end else begin
			for (int c = 0; c < vt_pkg::NUM_COMP; c++) begin
				item_in.data[c] = s_axis_tdata[IW + CW + c*CW +: CW];
			end
		end
	end

	assign s_axis_tready = (count_q != CNT_W'(DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign do_pop        = pop && head.valid;

	// head of the queue
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/vt_back.sv
// vt_back: execution side of the vertex transform engine
// owns the coefficient matrix, multiplies, sums, shifts and saturates
// depends on vt_pkg
module vt_back #(
	parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vt_pkg::head_t                  head,
	output logic                           pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_x, out_y, out_z, out_w (lowest bit first)
	output logic [vt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// clipped
	output logic                           m_axis_tuser
);

	localparam int N   = vt_pkg::NUM_COMP;
	localparam int CW  = vt_pkg::COMP_W;
	localparam int PW  = vt_pkg::PROD_W;
	localparam int SW  = vt_pkg::SUM_W;
	localparam int IW  = vt_pkg::IDX_W;

	logic signed [CW-1:0] coef_q [vt_pkg::NUM_COEF];
	logic signed [PW-1:0] prod_s1 [N][N];
	logic                 valid_s1;
	logic signed [SW-1:0] sum_s2 [N];
	logic                 valid_s2;
	logic [vt_pkg::OUT_TDATA_W-1:0] tdata_q;
	logic                 clip_q;
	logic                 valid_q;
	logic                 advance;
	logic                 is_load;
	logic                 take_xform;
	logic [vt_pkg::OUT_TDATA_W-1:0] res_data;
	logic                 res_clip;

	// whole pipeline moves when the output register can take a beat
	assign advance    = !valid_q || m_axis_tready;
	assign is_load    = head.valid && (head.item.kind == vt_pkg::KIND_LOAD);
	assign take_xform = head.valid && (head.item.kind == vt_pkg::KIND_XFORM) && advance;
	assign pop        = is_load || take_xform;

	// coefficient matrix, column-major, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vt_pkg::NUM_COEF; i++) begin
				coef_q[i] <= ((i % (N + 1)) == 0) ? CW'(1) << FRAC_BITS : '0;
			end
		end else if (is_load) begin
			coef_q[head.item.coef_index] <= head.item.data[0];
		end
	end

	// stage 1: sixteen full-width products
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < N; r++) begin
				for (int c = 0; c < N; c++) begin
					prod_s1[r][c] <= coef_q[IW'(c*N + r)] * head.item.data[c];
				end
			end
		end
	end

	// stage 2: row sums at full width
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < N; r++) begin
				sum_s2[r] <= SW'(prod_s1[r][0]) + SW'(prod_s1[r][1])
				           + SW'(prod_s1[r][2]) + SW'(prod_s1[r][3]);
			end
		end
	end

	// shift with floor and saturate each component
	always_comb begin
		logic signed [SW-1:0] shifted;
		logic [SW-CW:0]       top;
		res_clip = 1'b0;
		res_data = '0;
		for (int r = 0; r < N; r++) begin
			shifted = sum_s2[r] >>> FRAC_BITS;
			top     = shifted[SW-1:CW-1];
			if ((&top) || !(|top)) begin
				res_data[r*CW +: CW] = shifted[CW-1:0];
			end else begin
				res_clip = 1'b1;
				res_data[r*CW +: CW] = shifted[SW-1] ? {1'b1, {(CW-1){1'b0}}}
				                                     : {1'b0, {(CW-1){1'b1}}};
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			tdata_q <= res_data;
			clip_q  <= res_clip;
		end
	end

	// valid bits along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (advance) begin
			valid_s1 <= take_xform;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = clip_q;

endmodule

FILE: hw/rtl/vertex_transform_4x4.sv
// vertex_transform_4x4: top level of the vertex transform engine
// ties the front (accept and queue) to the back (matrix, multiply, saturate)
// depends on vt_pkg, vt_front, vt_back
//
// Usage: beats arrive on the s_axis channel. tuser is the kind: 0 loads one
// coefficient (coef_index col*4+row, coef_value in tdata), 1 transforms the
// vector x,y,z,w in tdata. A transform gives one m_axis beat with the four
// saturated Q16.16 components in tdata and the clipped flag in tuser; a load
// gives no beat and affects every transform accepted after it.
// Throughput: one beat per cycle, loads and transforms alike, while the output
// is not stalled. Path: with nothing ahead of it, a transform is written into
// the queue at its accept edge, then passes the product stage, sum stage and
// output register before its result is valid; a load is written into the
// matrix at the edge after it reaches the queue head.
// Reset (arst_n low) empties the queue and pipeline and sets the matrix to
// identity. While an output beat waits on m_axis_tready the pipeline holds;
// the two-entry queue keeps taking beats until full, then s_axis_tready drops.
module vertex_transform_4x4 #(
	parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// coef_index, coef_value, in_x, in_y, in_z, in_w, zero pad (lowest bit first)
	input  logic [vt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_x, out_y, out_z, out_w (lowest bit first)
	output logic [vt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// clipped
	output logic                           m_axis_tuser
);

	vt_pkg::head_t head;
	logic          pop;

	// accept and queue
	vt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.head          (head),
		.pop           (pop)
	);

	// matrix and arithmetic
	vt_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
